// ===== sv/fair_reader_writer_lock_defines.svh =====
// ---------------------------------------------------------------------------
// fair_reader_writer_lock_defines.svh
// Assertion macros shared by the lock manager RTL. Each macro samples on the
// rising edge of clk and is disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef FAIR_READER_WRITER_LOCK_DEFINES_SVH
`define FAIR_READER_WRITER_LOCK_DEFINES_SVH

// Condition must never hold
`define FRWL_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define FRWL_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FRWL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/frwl_pkg.sv =====
// ---------------------------------------------------------------------------
// frwl_pkg
// Types, constants and helpers for the FIFO-fair reader/writer lock manager.
// ---------------------------------------------------------------------------
package frwl_pkg;

  // Sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_GRANTS  = 16;
  localparam int READER_MAX  = 31;
  localparam int ID_W        = 4;
  localparam int RC_W        = $clog2(READER_MAX + 1);
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int GCNT_W      = $clog2(MAX_GRANTS + 1);

  // Request codes
  typedef enum logic [1:0] {
    REQ_BEGIN_READ  = 2'd0,
    REQ_END_READ    = 2'd1,
    REQ_BEGIN_WRITE = 2'd2,
    REQ_END_WRITE   = 2'd3
  } req_type_e_t;

  // Result status codes
  localparam logic STATUS_GRANTED  = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_SERVE
  } state_t;

  // One waiting request
  typedef struct packed {
    logic            is_writer;
    logic [ID_W-1:0] id;
  } wq_entry_t;

  // Controller to wait queue
  typedef struct packed {
    logic      push;
    logic      pop;
    wq_entry_t push_entry;
  } wq_ctrl_t;

  // Wait queue to controller
  typedef struct packed {
    logic      empty;
    logic      full;
    wq_entry_t head_entry;
  } wq_stat_t;

  // Reader count increment, saturating
  function automatic logic [RC_W-1:0] rc_inc(input logic [RC_W-1:0] rc);
    return (rc == RC_W'(READER_MAX)) ? rc : rc + 1'b1;
  endfunction

endpackage

// ===== sv/frwl_wait_queue.sv =====
// ---------------------------------------------------------------------------
// frwl_wait_queue
// Ring of waiting requests in a synchronous memory. The head entry is read
// ahead, registered, from the next head index, so after a pop the new head is
// on head_entry in the following cycle.
// ---------------------------------------------------------------------------
`include "fair_reader_writer_lock_defines.svh"

module frwl_wait_queue (
  input  logic               clk,
  input  logic               rst,
  input  frwl_pkg::wq_ctrl_t ctrl,
  output frwl_pkg::wq_stat_t stat
);

  frwl_pkg::wq_entry_t              mem [frwl_pkg::QUEUE_DEPTH];
  frwl_pkg::wq_entry_t              rd_entry;
  logic [frwl_pkg::QIDX_W-1:0]      head;
  logic [frwl_pkg::QIDX_W-1:0]      tail;
  logic [frwl_pkg::QIDX_W-1:0]      head_next;
  logic [frwl_pkg::QIDX_W-1:0]      tail_next;
  logic [frwl_pkg::QCNT_W-1:0]      count;
  logic [frwl_pkg::QCNT_W-1:0]      count_next;

  function automatic logic [frwl_pkg::QIDX_W-1:0] ring_inc(
    input logic [frwl_pkg::QIDX_W-1:0] i
  );
    return (i == frwl_pkg::QIDX_W'(frwl_pkg::QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // Pointer and count update
  always_comb begin
    head_next  = ctrl.pop  ? ring_inc(head) : head;
    tail_next  = ctrl.push ? ring_inc(tail) : tail;
    count_next = count;
    if (ctrl.push && !ctrl.pop) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop && !ctrl.push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Memory: write at tail, registered read at the upcoming head.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail] <= ctrl.push_entry;
    end
    rd_entry <= mem[head_next];
  end

  assign stat.empty      = (count == '0);
  assign stat.full       = (count == frwl_pkg::QCNT_W'(frwl_pkg::QUEUE_DEPTH));
  assign stat.head_entry = rd_entry;

  // Checks
  `FRWL_ASSERT_IMPLIES(a_push_not_full, ctrl.push, !stat.full, "push into full queue")
  `FRWL_ASSERT_IMPLIES(a_pop_not_empty, ctrl.pop, !stat.empty, "pop from empty queue")
  `FRWL_ASSERT_NEVER(a_count_range, count > frwl_pkg::QCNT_W'(frwl_pkg::QUEUE_DEPTH), "queue count overflow")

endmodule

// ===== sv/fair_reader_writer_lock.sv =====
// ---------------------------------------------------------------------------
// fair_reader_writer_lock
// FIFO-fair reader/writer lock manager. Begin requests are granted at once
// or queued (rejected when the queue is full); releases grant waiters from
// the head of the queue in order.
//
//   Channel   Dir  Fields
//   s_axis    in   tuser[1:0] req_type, tdata[3:0] requester_id
//   m_axis    out  tdata[3:0] grant_id, tuser[0] grant_is_writer,
//                  tuser[1] status, tlast last
//
// A begin request's result, if any, is loaded at accept.
// Releases grant k waiters (k <= 16) from the queue, one grant per cycle while
// the output does not stall, paced by the wait queue's single registered read
// port, then close the run and mark its last item.
// Output stalls hold the controller; a request is accepted only when the
// output register is empty or its item leaves in that cycle.
// Reset (rst, synchronous) empties the queue and clears the lock state.
// ---------------------------------------------------------------------------
`include "fair_reader_writer_lock_defines.svh"

module fair_reader_writer_lock (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] requester_id, [7:4] zero
  input  logic [1:0] s_axis_tuser,   // [1:0] req_type
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] grant_id, [7:4] zero
  output logic [1:0] m_axis_tuser,   // [0] grant_is_writer, [1] status
  output logic       m_axis_tlast
);

  frwl_pkg::state_t               state;
  frwl_pkg::state_t               state_next;
  frwl_pkg::req_type_e_t          req;
  frwl_pkg::wq_ctrl_t             wq_ctrl;
  frwl_pkg::wq_stat_t             wq_stat;
  frwl_pkg::wq_entry_t            in_entry;

  logic [frwl_pkg::RC_W-1:0]      reader_count;
  logic [frwl_pkg::RC_W-1:0]      reader_count_next;
  logic                           writer_active;
  logic                           writer_active_next;
  logic [frwl_pkg::GCNT_W-1:0]    grant_cnt;
  logic [frwl_pkg::GCNT_W-1:0]    grant_cnt_next;

  // Held grant, waiting to learn whether it ends the run
  logic                           pend_valid;
  logic                           pend_valid_next;
  frwl_pkg::wq_entry_t            pend;
  frwl_pkg::wq_entry_t            pend_next;

  // Output register
  logic                           out_valid;
  logic                           out_valid_next;
  frwl_pkg::wq_entry_t            out_entry;
  frwl_pkg::wq_entry_t            out_entry_next;
  logic                           out_status;
  logic                           out_status_next;
  logic                           out_last;
  logic                           out_last_next;

  logic                           out_free;
  logic                           in_fire;
  logic                           is_release;
  logic                           can_grant;

  assign req          = frwl_pkg::req_type_e_t'(s_axis_tuser);
  assign in_entry.id  = s_axis_tdata[frwl_pkg::ID_W-1:0];
  assign in_entry.is_writer = (req == frwl_pkg::REQ_BEGIN_WRITE);
  assign is_release   = (req == frwl_pkg::REQ_END_READ) || (req == frwl_pkg::REQ_END_WRITE);

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == frwl_pkg::ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Head of queue may be granted now
  assign can_grant = !wq_stat.empty
                  && (grant_cnt < frwl_pkg::GCNT_W'(frwl_pkg::MAX_GRANTS))
                  && !writer_active
                  && !(wq_stat.head_entry.is_writer && (reader_count != '0));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      frwl_pkg::ST_IDLE: begin
        if (in_fire && is_release) begin
          state_next = frwl_pkg::ST_SERVE;
        end
      end
      frwl_pkg::ST_SERVE: begin
        if (!can_grant && (!pend_valid || out_free)) begin
          state_next = frwl_pkg::ST_IDLE;
        end
      end
      default: state_next = frwl_pkg::ST_IDLE;
    endcase
  end

  // Datapath and queue control
  always_comb begin
    reader_count_next  = reader_count;
    writer_active_next = writer_active;
    grant_cnt_next     = grant_cnt;
    pend_valid_next    = pend_valid;
    pend_next          = pend;
    out_valid_next     = out_valid && !m_axis_tready;
    out_entry_next     = out_entry;
    out_status_next    = out_status;
    out_last_next      = out_last;
    wq_ctrl.push       = 1'b0;
    wq_ctrl.pop        = 1'b0;
    wq_ctrl.push_entry = in_entry;

    unique case (state)
      frwl_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (req)
            frwl_pkg::REQ_BEGIN_READ,
            frwl_pkg::REQ_BEGIN_WRITE: begin
              if (wq_stat.empty && !writer_active &&
                  (!in_entry.is_writer || (reader_count == '0))) begin
                // Immediate grant
                if (in_entry.is_writer) begin
                  writer_active_next = 1'b1;
                end else begin
                  reader_count_next = frwl_pkg::rc_inc(reader_count);
                end
                out_valid_next  = 1'b1;
                out_entry_next  = in_entry;
                out_status_next = frwl_pkg::STATUS_GRANTED;
                out_last_next   = 1'b1;
              end else if (wq_stat.full) begin
                out_valid_next  = 1'b1;
                out_entry_next  = in_entry;
                out_status_next = frwl_pkg::STATUS_REJECTED;
                out_last_next   = 1'b1;
              end else begin
                wq_ctrl.push = 1'b1;
              end
            end
            frwl_pkg::REQ_END_READ: begin
              if (reader_count != '0) begin
                reader_count_next = reader_count - 1'b1;
              end
              grant_cnt_next = '0;
            end
            frwl_pkg::REQ_END_WRITE: begin
              writer_active_next = 1'b0;
              grant_cnt_next     = '0;
            end
            default: begin
              grant_cnt_next = '0;
            end
          endcase
        end
      end
      frwl_pkg::ST_SERVE: begin
        if (can_grant && (!pend_valid || out_free)) begin
          // Grant the head; the held grant, if any, was not the last
          wq_ctrl.pop     = 1'b1;
          pend_valid_next = 1'b1;
          pend_next       = wq_stat.head_entry;
          grant_cnt_next  = grant_cnt + 1'b1;
          if (wq_stat.head_entry.is_writer) begin
            writer_active_next = 1'b1;
          end else begin
            reader_count_next = frwl_pkg::rc_inc(reader_count);
          end
          if (pend_valid) begin
            out_valid_next  = 1'b1;
            out_entry_next  = pend;
            out_status_next = frwl_pkg::STATUS_GRANTED;
            out_last_next   = 1'b0;
          end
        end else if (!can_grant && pend_valid && out_free) begin
          // Run ends: flush the held grant as last
          pend_valid_next = 1'b0;
          out_valid_next  = 1'b1;
          out_entry_next  = pend;
          out_status_next = frwl_pkg::STATUS_GRANTED;
          out_last_next   = 1'b1;
        end
      end
      default: begin
        pend_valid_next = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= frwl_pkg::ST_IDLE;
      reader_count  <= '0;
      writer_active <= 1'b0;
      grant_cnt     <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      reader_count  <= reader_count_next;
      writer_active <= writer_active_next;
      grant_cnt     <= grant_cnt_next;
      pend_valid    <= pend_valid_next;
      out_valid     <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend       <= pend_next;
    out_entry  <= out_entry_next;
    out_status <= out_status_next;
    out_last   <= out_last_next;
  end

  frwl_wait_queue u_wait_queue (
    .clk  (clk),
    .rst  (rst),
    .ctrl (wq_ctrl),
    .stat (wq_stat)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(8 - frwl_pkg::ID_W){1'b0}}, out_entry.id};
  assign m_axis_tuser  = {out_status, out_entry.is_writer};
  assign m_axis_tlast  = out_last;

  // Checks
  `FRWL_ASSERT_NEVER(a_lock_exclusive, writer_active && (reader_count != '0), "writer and readers hold lock")
  `FRWL_ASSERT_IMPLIES(a_pend_in_serve, pend_valid, state == frwl_pkg::ST_SERVE, "held grant outside serve")
  `FRWL_ASSERT_NEVER(a_grant_bound, grant_cnt > frwl_pkg::GCNT_W'(frwl_pkg::MAX_GRANTS), "too many grants in run")

endmodule
